[design/scpa_pkg.sv]
// Package of shared constants, codes and types for the size-class pool allocator.
package scpa_pkg;

  localparam int DEF_POOL_COUNT      = 4;
  localparam int DEF_MIN_BLOCK_BYTES = 16;
  localparam int DEF_PAGE_BYTES      = 4096;
  localparam int DEF_PAGE_TOTAL      = 64;

  localparam int ADDR_W      = 15;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int WORD_SHIFT  = 3;
  localparam int LIMIT_W     = 7;
  localparam int SIZE_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int OUT_POOL_W  = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  localparam logic [1:0] KIND_CONTIG = 2'd0;
  localparam logic [1:0] KIND_PTR    = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_PRE   = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_OVER   = 2'd1;
  localparam logic [1:0] ST_NOPAGE = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [1:0] kind;
    addr_t      addr;
  } link_t;

endpackage

[design/size_class_pool_allocator.sv]
// Top level of the size-class pool allocator: request sequencer, pool heads and page source.
//
//   channel   direction  tdata (low bit up)                          tuser
//   in_       slave      req_size[15:0] block_addr[30:16]            req_type
//                        page_count[37:31], zero pad to 40
//   out_      master     granted_addr[14:0] pool_index[17:15],       status
//                        zero pad to 24
//   cfg_      write      page_limit                                  -
//
// One request is handled at a time. A free or an oversize request passes EXEC and FIN to the
// result register; an allocate from a non-empty pool passes EXEC, LINK and FIN, one that
// first takes a fresh page EXEC, RD, LINK and FIN, and a preallocate EXEC, repeated PRE
// steps and FIN. The link store's single registered read port sets the allocate path.
// After reset a clearing pass writes all 32768 link words, one per cycle, before the first
// request is taken. A stalled result holds the block until the output register is free.
module size_class_pool_allocator #(
  parameter int POOL_COUNT      = scpa_pkg::DEF_POOL_COUNT,
  parameter int MIN_BLOCK_BYTES = scpa_pkg::DEF_MIN_BLOCK_BYTES,
  parameter int PAGE_BYTES      = scpa_pkg::DEF_PAGE_BYTES,
  parameter int PAGE_TOTAL      = scpa_pkg::DEF_PAGE_TOTAL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [scpa_pkg::IN_DATA_W-1:0]    in_tdata,   // req_size, block_addr, page_count
  input  logic [1:0]                        in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [scpa_pkg::OUT_DATA_W-1:0]   out_tdata,  // granted_addr, pool_index
  output logic [1:0]                        out_tuser,  // status
  input  logic                              cfg_wr_en,
  input  logic [scpa_pkg::LIMIT_W-1:0]      cfg_wr_data // page_limit
);
  import scpa_pkg::*;

  localparam int PSEL_W = $clog2(POOL_COUNT + 1);
  localparam int PIDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int NP_W   = ($clog2(PAGE_TOTAL + 1) > LIMIT_W) ? $clog2(PAGE_TOTAL + 1) : LIMIT_W;
  localparam int PAGE_WORDS = PAGE_BYTES / 8;
  localparam int BW_W   = 18;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_PRE   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]            state_r, state_nxt;
  addr_t                 clr_cnt_r, clr_cnt_nxt;
  logic [LIMIT_W-1:0]    page_limit_r;
  logic [NP_W-1:0]       next_page_r, next_page_nxt;
  addr_t                 head_r [POOL_COUNT];
  logic [POOL_COUNT-1:0] hv_r, hv_nxt;
  logic                  head_we;
  addr_t                 head_wdata;

  logic [1:0]            type_r;
  logic [PSEL_W-1:0]     pool_r;
  addr_t                 baddr_r;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  addr_t                 res_addr_r, res_addr_nxt;
  logic [1:0]            res_status_r, res_status_nxt;

  logic                  out_valid_r;
  addr_t                 out_addr_r;
  logic [1:0]            out_status_r;
  logic [OUT_POOL_W-1:0] out_pool_r;

  logic                  mem_we;
  addr_t                 mem_waddr;
  link_t                 mem_wdata, mem_rdata;
  addr_t                 mem_raddr;

  logic                  accept;
  logic [PSEL_W-1:0]     pick;
  logic [PIDX_W-1:0]     pidx;
  addr_t                 cur_head;
  logic                  cur_hv;
  link_t                 old_link;
  logic [BW_W-1:0]       bw;
  logic [NP_W-1:0]       avail;
  logic                  no_page;
  logic [31:0]           base_full;
  addr_t                 page_base, page_last;
  logic [BW_W-1:0]       last_off;
  logic                  out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    pick = PSEL_W'(POOL_COUNT);
    for (int i = POOL_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, in_tdata[SIZE_W-1:0]} < 17'(MIN_BLOCK_BYTES << i)) begin
        pick = PSEL_W'(i);
      end
    end
  end

  assign pidx     = pool_r[PIDX_W-1:0];
  assign cur_head = head_r[pidx];
  assign cur_hv   = hv_r[pidx];
  assign old_link = cur_hv ? link_t'{kind: KIND_PTR, addr: cur_head}
                           : link_t'{kind: KIND_END, addr: '0};
  assign bw       = BW_W'((BW_W'(MIN_BLOCK_BYTES) << pool_r) >> WORD_SHIFT);

  assign avail     = (NP_W'(page_limit_r) < NP_W'(PAGE_TOTAL)) ? NP_W'(page_limit_r)
                                                                : NP_W'(PAGE_TOTAL);
  assign no_page   = (next_page_r >= avail);
  assign base_full = 32'(next_page_r) * 32'(PAGE_WORDS);
  assign page_base = base_full[ADDR_W-1:0];
  assign last_off  = (BW_W'(PAGE_WORDS) >= bw) ? (BW_W'(PAGE_WORDS) - bw) : '0;
  assign page_last = page_base + last_off[ADDR_W-1:0];

  assign mem_raddr = cur_head;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    next_page_nxt  = next_page_r;
    hv_nxt         = hv_r;
    head_we        = 1'b0;
    head_wdata     = page_base;
    cnt_nxt        = cnt_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = page_last;
    mem_wdata      = old_link;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_DONE;
          cnt_nxt        = in_tdata[37:31];
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        if (type_r == REQ_NOP) begin
          res_status_nxt = ST_DONE;
        end else if (pool_r == PSEL_W'(POOL_COUNT)) begin
          res_status_nxt = ST_OVER;
        end else begin
          case (type_r)
            REQ_ALLOC: begin
              if (cur_hv) begin
                state_nxt = S_LINK;
              end else if (no_page) begin
                res_status_nxt = ST_NOPAGE;
              end else begin
                mem_we        = 1'b1;
                head_we       = 1'b1;
                hv_nxt[pidx]  = 1'b1;
                next_page_nxt = next_page_r + 1'b1;
                state_nxt     = S_RD;
              end
            end
            REQ_FREE: begin
              mem_we       = 1'b1;
              mem_waddr    = baddr_r;
              head_we      = 1'b1;
              head_wdata   = baddr_r;
              hv_nxt[pidx] = 1'b1;
            end
            default: begin
              state_nxt = S_PRE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        res_addr_nxt = cur_head;
        state_nxt    = S_FIN;
        case (mem_rdata.kind)
          KIND_CONTIG: begin
            head_we    = 1'b1;
            head_wdata = cur_head + bw[ADDR_W-1:0];
          end
          KIND_PTR: begin
            head_we    = 1'b1;
            head_wdata = mem_rdata.addr;
          end
          default: begin
            hv_nxt[pidx] = 1'b0;
          end
        endcase
      end
      S_PRE: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else if (no_page) begin
          res_status_nxt = ST_NOPAGE;
          state_nxt      = S_FIN;
        end else begin
          mem_we        = 1'b1;
          head_we       = 1'b1;
          hv_nxt[pidx]  = 1'b1;
          next_page_nxt = next_page_r + 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      next_page_r  <= '0;
      hv_r         <= '0;
      page_limit_r <= LIMIT_W'(64);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_page_r <= next_page_nxt;
      hv_r        <= hv_nxt;
      if (cfg_wr_en) begin
        page_limit_r <= cfg_wr_data;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (head_we) begin
      head_r[pidx] <= head_wdata;
    end
    if (accept) begin
      type_r  <= in_tuser;
      pool_r  <= (in_tuser == REQ_NOP) ? '0 : pick;
      baddr_r <= in_tdata[30:16];
    end
    if (state_r == S_FIN && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_pool_r   <= OUT_POOL_W'(pool_r);
    end
  end

  scpa_link_mem u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ADDR_W - OUT_POOL_W){1'b0}}, out_pool_r, out_addr_r};
  assign out_tuser  = out_status_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("A request was accepted outside the idle state.");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r && !in_tready)
    else $error("The block was active during the clearing pass.");

  a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_page_r <= NP_W'(PAGE_TOTAL))
    else $error("More pages were granted than the page source holds.");

  a_link_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LINK |-> cur_hv)
    else $error("A link word was used for a pool with an empty list.");

endmodule

[design/scpa_link_mem.sv]
// Link store: single-port-write, registered-read synchronous memory of link words.
module scpa_link_mem (
  input  logic           clk,
  input  logic           we,
  input  scpa_pkg::addr_t waddr,
  input  scpa_pkg::link_t wdata,
  input  scpa_pkg::addr_t raddr,
  output scpa_pkg::link_t rdata
);
  import scpa_pkg::*;

  link_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[dv/size_class_pool_allocator_tb.sv]
// Self-checking testbench for the size-class pool allocator: directed table, then random requests.
module size_class_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scpa_pkg::*;

  localparam int NPOOL = DEF_POOL_COUNT;
  localparam int PAGE_WORDS = DEF_PAGE_BYTES / 8;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [15:0] size;
    logic [14:0] addr;
    logic [6:0]  count;
  } req_t;

  typedef struct packed {
    logic [14:0] granted;
    logic [1:0]  status;
    logic [2:0]  pool;
  } resp_t;

  typedef struct packed {
    req_t  rq;
    logic  has_exp;
    resp_t exp;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;

  size_class_pool_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial forever #5 clk = ~clk;

  // Predictor state
  logic [14:0] m_head [NPOOL];
  logic        m_valid [NPOOL];
  logic [16:0] m_link [logic [14:0]];
  int unsigned m_next_page;
  int unsigned m_limit;

  resp_t expected_q[$];
  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int idle_in = 0, idle_out = 0;
  int wdog = 0;

  function automatic logic [16:0] link_at(logic [14:0] a);
    return m_link.exists(a) ? m_link[a] : 17'd0;
  endfunction

  function automatic int unsigned choose_pool(logic [15:0] s);
    for (int p = 0; p < NPOOL; p++)
      if (s < (DEF_MIN_BLOCK_BYTES << p)) return p;
    return NPOOL;
  endfunction

  function automatic logic [16:0] old_head(int p);
    return m_valid[p] ? {KIND_PTR, m_head[p]} : {KIND_END, 15'd0};
  endfunction

  function automatic bit take_page(int p);
    int unsigned avail, bw, base, last;
    avail = m_limit < DEF_PAGE_TOTAL ? m_limit : DEF_PAGE_TOTAL;
    bw = (DEF_MIN_BLOCK_BYTES << p) / 8;
    if (m_next_page >= avail) return 0;
    base = (m_next_page * PAGE_WORDS) & 32'h7FFF;
    last = (base + (PAGE_WORDS >= bw ? PAGE_WORDS - bw : 0)) & 32'h7FFF;
    m_link[last[14:0]] = old_head(p);
    m_head[p] = base[14:0];
    m_valid[p] = 1;
    m_next_page++;
    return 1;
  endfunction

  function automatic resp_t predict_grant(req_t rq);
    resp_t r;
    int unsigned p;
    logic [14:0] h;
    logic [16:0] lk;
    r = '0;
    if (rq.rtype == REQ_NOP) return r;
    p = choose_pool(rq.size);
    r.pool = p[2:0];
    if (p >= NPOOL) begin
      r.status = ST_OVER;
    end else if (rq.rtype == REQ_ALLOC) begin
      if (!m_valid[p] && !take_page(p)) begin
        r.status = ST_NOPAGE;
      end else begin
        h = m_head[p];
        lk = link_at(h);
        r.granted = h;
        if (lk[16:15] == KIND_CONTIG) m_head[p] = h + 15'((DEF_MIN_BLOCK_BYTES << p) / 8);
        else if (lk[16:15] == KIND_PTR) m_head[p] = lk[14:0];
        else m_valid[p] = 0;
      end
    end else if (rq.rtype == REQ_FREE) begin
      m_link[rq.addr] = old_head(p);
      m_head[p] = rq.addr;
      m_valid[p] = 1;
    end else begin
      for (int i = 0; i < rq.count; i++)
        if (!take_page(p)) begin
          r.status = ST_NOPAGE;
          break;
        end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch #%0d at result %0d: %s got %0d expected %0d",
             errors, n_checked, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{granted: out_tdata[14:0], status: out_tuser, pool: out_tdata[17:15]};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, granted_addr", got.granted, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.granted !== want.granted) report_mismatch("granted_addr", got.granted, want.granted);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.pool !== want.pool) report_mismatch("pool_index", got.pool, want.pool);
      end
      n_checked++;
    end
  end

  // Receiver stalls and watchdog
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_out);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("** size_class_pool_allocator: FAILED **");
      $finish;
    end
  end

  task automatic send_request(req_t rq, bit has_exp, resp_t exp);
    resp_t pred;
    while ($urandom_range(99) < idle_in) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= rq.rtype;
    in_tdata <= {2'b0, rq.count, rq.addr, rq.size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_grant(rq);
    if (has_exp && pred !== exp)
      report_mismatch("table row disagrees with predictor, word", pred, exp);
    expected_q.push_back(pred);
    n_sent++;
  endtask

  task automatic drain_and_set_limit(int unsigned lim);
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= lim[6:0];
    @(posedge clk);
    cfg_wr_en <= 0;
    m_limit = lim;
  endtask

  function automatic req_t random_request();
    req_t rq;
    int k;
    rq.rtype = 2'($urandom_range(3));
    k = $urandom_range(99);
    rq.size = k < 85 ? 16'($urandom_range(127)) : 16'($urandom);
    rq.addr = 15'($urandom);
    rq.count = k < 80 ? 7'($urandom_range(2)) : 7'($urandom_range(127));
    if (rq.rtype != REQ_PRE && $urandom_range(9) < 6) rq.rtype = REQ_ALLOC;
    if (rq.rtype == REQ_FREE && m_valid[choose_pool(rq.size) % NPOOL] && $urandom_range(3) != 0)
      rq.addr = m_head[choose_pool(rq.size) % NPOOL] - 15'(8);
    return rq;
  endfunction

  row_t dir_table[$];

  initial begin
    row_t rw;
    int unsigned limits[3];
    for (int p = 0; p < NPOOL; p++) begin
      m_head[p] = '0;
      m_valid[p] = 0;
    end
    m_next_page = 0;
    m_limit = 64;
    //              type      size      addr      count  exp  granted status pool
    dir_table.push_back('{'{REQ_NOP, 16'hFFFF, 15'h7FFF, 7'h7F}, 1, '{0, ST_DONE, 0}});
    dir_table.push_back('{'{REQ_ALLOC, 16'hFFFF, 15'h0, 7'h0}, 1, '{0, ST_OVER, 4}});
    dir_table.push_back('{'{REQ_FREE, 16'd128, 15'h7FFF, 7'h0}, 1, '{0, ST_OVER, 4}});
    dir_table.push_back('{'{REQ_ALLOC, 16'd0, 15'h0, 7'h0}, 1, '{0, ST_DONE, 0}});
    dir_table.push_back('{'{REQ_ALLOC, 16'd15, 15'h0, 7'h0}, 1, '{2, ST_DONE, 0}});
    dir_table.push_back('{'{REQ_ALLOC, 16'd16, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_ALLOC, 16'd127, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_FREE, 16'd0, 15'h7FFF, 7'h0}, 1, '{0, ST_DONE, 0}});
    dir_table.push_back('{'{REQ_ALLOC, 16'd1, 15'h0, 7'h0}, 1, '{15'h7FFF, ST_DONE, 0}});
    dir_table.push_back('{'{REQ_ALLOC, 16'd1, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_PRE, 16'd40, 15'h0, 7'd2}, 0, '0});
    dir_table.push_back('{'{REQ_ALLOC, 16'd40, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_FREE, 16'd100, 15'd600, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_ALLOC, 16'd100, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_PRE, 16'd20, 15'h0, 7'd64}, 0, '0});
    dir_table.push_back('{'{REQ_ALLOC, 16'd127, 15'h0, 7'h0}, 0, '0});
    dir_table.push_back('{'{REQ_PRE, 16'd0, 15'h0, 7'd127}, 1, '{0, ST_NOPAGE, 0}});
    dir_table.push_back('{'{REQ_PRE, 16'd0, 15'h0, 7'd0}, 1, '{0, ST_DONE, 0}});

    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    idle_in = 18;
    idle_out = 78;
    foreach (dir_table[i]) send_request(dir_table[i].rq, dir_table[i].has_exp, dir_table[i].exp);

    // Exhausted source: a fresh allocate must report out of pages.
    drain_and_set_limit(1);
    for (int p = 0; p < NPOOL; p++) begin
      rw.rq = '{REQ_ALLOC, 16'(DEF_MIN_BLOCK_BYTES << p) - 16'd1, 15'h0, 7'h0};
      send_request(rw.rq, 0, '0);
    end

    limits = '{64, 127, 5};
    for (int ph = 0; ph < 3; ph++) begin
      drain_and_set_limit(ph == 1 ? 127 : limits[ph]);
      if (ph == 1) begin
        idle_in = 78;
        idle_out = 18;
      end else if (ph == 2) begin
        idle_in = 0;
        idle_out = 0;
      end
      for (int n = 0; n < 270; n++) send_request(random_request(), 0, '0);
    end

    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests and checked %0d results over limits 1, 5, 64 and 127,",
             n_sent, n_checked);
    $display("with stalls on the request side, the result side and neither.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** size_class_pool_allocator: PASSED **");
    end else begin
      $display("** size_class_pool_allocator: FAILED **");
    end
    $finish;
  end
endmodule
